// File: rtl/reservoir_sampler_random_draw_top_defines.svh
// Assertion macros for the reservoir sampler checks.
`ifndef RESERVOIR_SAMPLER_RANDOM_DRAW_TOP_DEFINES_SVH
`define RESERVOIR_SAMPLER_RANDOM_DRAW_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RSRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("reservoir sampler check failed");
`define RSRD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("reservoir sampler check failed");
`else
`define RSRD_ASSERT(lbl, prop)
`define RSRD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/rsrd_pkg.sv
// Shared constants, codes and controller/datapath types of the reservoir sampler.
package rsrd_pkg;

  localparam int POOL_DEPTH  = 256;
  localparam int MAP_TILES   = 65536;
  localparam int MAX_WANT    = 64;
  localparam int POOL_ADDR_W = $clog2(POOL_DEPTH);
  localparam int POOL_CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int MAP_ADDR_W  = $clog2(MAP_TILES);
  localparam int TILE_W      = 16;
  localparam int WANT_W      = 7;
  localparam int CAP_W       = 9;
  localparam int RAND_W      = 15;
  localparam int DIV_CNT_W   = $clog2(RAND_W + 1);

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_INC = 32'd12345;

  typedef enum logic [1:0] {
    KIND_OFFER   = 2'd0,
    KIND_DRAW    = 2'd1,
    KIND_MARK    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_CAPACITY = 1'b0,
    CFG_SEED     = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic seen_inc;
    logic append;
    logic rng_step;
    logic div_start;
    logic div_draw;
    logic rep_wr;
    logic restart;
    logic mark_wr;
    logic draw_init;
    logic rd_last;
    logic latch_t;
    logic swap_wr;
    logic place;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  clr_last;
    logic  below_cap;
    logic  div_busy;
    logic  j_lt_cap;
    logic  want_zero;
    logic  rem_zero;
    logic  placed_full;
    logic  occ_busy;
  } ctrl_sts_t;

endpackage

// File: rtl/reservoir_sampler_random_draw_top.sv
// Top level of the reservoir sampler with random draw.
//
// Keeps a reservoir of up to 256 tile indices (algorithm R) and draws from it
// at random without replacement, marking each placed tile in a 65536-entry
// occupancy map. An item is accepted when start is high and busy is low; busy
// stays high until the item has finished. After reset the occupancy map is
// cleared one tile a cycle, and busy stays high until all of it is clear;
// configuration writes are taken at any time (cfg_ready is always high). An
// offer on the replacement path and each pool entry that a draw consumes go
// through the 15-step remainder unit. Results cannot be held off: each
// sits on the result ports for one cycle with strobe high, and the final
// result of a draw carries last; a draw that places nothing gives one empty
// transaction.
module reservoir_sampler_random_draw_top
  import rsrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [TILE_W-1:0] tile_index,
  input  logic [WANT_W-1:0] want,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              strobe,
  output logic [TILE_W-1:0] placed_tile,
  output logic              placed_valid,
  output logic [WANT_W-1:0] placed_so_far,
  output logic              last
);

`include "reservoir_sampler_random_draw_top_defines.svh"

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // accept configuration transactions in every cycle
  assign cfg_ready = 1'b1;

  rsrd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  rsrd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (kind),
    .tile_index    (tile_index),
    .want          (want),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .strobe        (strobe),
    .placed_tile   (placed_tile),
    .placed_valid  (placed_valid),
    .placed_so_far (placed_so_far),
    .last          (last)
  );

  // the final transaction of a draw coincides with the return to idle
  `RSRD_ASSERT(a_last_ends_item, strobe && last |-> !busy)
  // an empty transaction is always the only and final one
  `RSRD_ASSERT(a_empty_is_last, strobe && !placed_valid |-> last && placed_so_far == '0)
  // a placement always carries a non-zero count
  `RSRD_ASSERT(a_place_counts, strobe && placed_valid |-> placed_so_far != '0)
  // an accepted item keeps the block busy in the next cycle
  `RSRD_ASSERT(a_accept_busy, start && !busy |=> busy)

endmodule

// File: rtl/rsrd_ram.sv
// Generic simple dual-port RAM with registered read.
module rsrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rsrd_datapath.sv
// Datapath: generator, remainder unit, pool and occupancy memories, result register.
module rsrd_datapath
  import rsrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output ctrl_sts_t         sts,
  input  logic [1:0]        kind,
  input  logic [TILE_W-1:0] tile_index,
  input  logic [WANT_W-1:0] want,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              strobe,
  output logic [TILE_W-1:0] placed_tile,
  output logic              placed_valid,
  output logic [WANT_W-1:0] placed_so_far,
  output logic              last
);

  localparam logic [CAP_W-1:0]      CAP_MAX  = CAP_W'(POOL_DEPTH);
  localparam logic [WANT_W-1:0]     WANT_MAX = WANT_W'(MAX_WANT);
  localparam logic [MAP_ADDR_W-1:0] CLR_END  = MAP_ADDR_W'(MAP_TILES - 1);

  logic [CAP_W-1:0]      capacity;
  logic [31:0]           seed;
  logic [31:0]           rng;
  logic [31:0]           seen;
  logic [POOL_CNT_W-1:0] pool_count;
  kind_t                 kind_q;
  logic [TILE_W-1:0]     tile_q;
  logic [WANT_W-1:0]     want_q;
  logic [POOL_CNT_W-1:0] rem;
  logic [WANT_W-1:0]     placed;
  logic [TILE_W-1:0]     t;
  logic                  pend_valid;
  logic [TILE_W-1:0]     pend_tile;
  logic [WANT_W-1:0]     pend_cnt;
  logic [MAP_ADDR_W-1:0] clr_addr;

  // remainder unit
  logic                  div_run;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [RAND_W-1:0]     dvd;
  logic [31:0]           dvs;
  logic [RAND_W-1:0]     rmd;
  logic [RAND_W:0]       rmd_sh;
  logic [RAND_W:0]       rmd_sub;

  logic [CAP_W-1:0]       cap_now;
  logic [31:0]            rng_next;
  logic [POOL_ADDR_W-1:0] pool_raddr;
  logic                   pool_we;
  logic [POOL_ADDR_W-1:0] pool_waddr;
  logic [TILE_W-1:0]      pool_wdata;
  logic [TILE_W-1:0]      pool_rdata;
  logic                   occ_we;
  logic [MAP_ADDR_W-1:0]  occ_waddr;
  logic                   occ_wdata;
  logic                   occ_rdata;

  assign cap_now  = (capacity > CAP_MAX) ? CAP_MAX : capacity;
  assign rng_next = rng * LCG_MUL + LCG_INC;
  assign rmd_sh   = {rmd, dvd[RAND_W-1]};
  assign rmd_sub  = rmd_sh - dvs[RAND_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_W'(64);
      seed       <= 32'd1;
      rng        <= 32'd1;
      seen       <= '0;
      pool_count <= '0;
      clr_addr   <= '0;
      div_run    <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
          CFG_SEED:     seed     <= cfg_data;
        endcase
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load) begin
        kind_q <= kind_t'(kind);
        tile_q <= tile_index;
        want_q <= (want > WANT_MAX) ? WANT_MAX : want;
      end
      if (cmd.seen_inc && (seen != '1)) begin
        seen <= seen + 1'b1;
      end
      if (cmd.append) begin
        pool_count <= pool_count + 1'b1;
      end
      if (cmd.rng_step) begin
        rng <= rng_next;
      end
      if (cmd.restart) begin
        pool_count <= '0;
        seen       <= '0;
        rng        <= (seed == '0) ? 32'd1 : seed;
      end
      // start: dividend is the 15-bit draw of the generator
      if (cmd.div_start) begin
        div_run <= 1'b1;
        div_cnt <= DIV_CNT_W'(RAND_W);
        dvd     <= rng[30:16];
        rmd     <= '0;
        dvs     <= cmd.div_draw ? 32'(rem) : seen;
      end else if (div_run) begin
        if (32'(rmd_sh) >= dvs) begin
          rmd <= rmd_sub[RAND_W-1:0];
        end else begin
          rmd <= rmd_sh[RAND_W-1:0];
        end
        dvd     <= {dvd[RAND_W-2:0], 1'b0};
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == DIV_CNT_W'(1)) begin
          div_run <= 1'b0;
        end
      end
      if (cmd.draw_init) begin
        rem        <= pool_count;
        placed     <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.latch_t) begin
        t <= pool_rdata;
      end
      if (cmd.swap_wr) begin
        rem <= rem - 1'b1;
      end
      // one result is held back so that the final one can carry last
      if (cmd.place) begin
        placed     <= placed + 1'b1;
        pend_valid <= 1'b1;
        pend_tile  <= t;
        pend_cnt   <= placed + 1'b1;
        if (pend_valid) begin
          strobe        <= 1'b1;
          placed_tile   <= pend_tile;
          placed_valid  <= 1'b1;
          placed_so_far <= pend_cnt;
          last          <= 1'b0;
        end
      end
      if (cmd.finish) begin
        if (want_q != '0) begin
          pool_count <= rem;
        end
        pend_valid    <= 1'b0;
        strobe        <= 1'b1;
        last          <= 1'b1;
        placed_valid  <= pend_valid;
        placed_tile   <= pend_valid ? pend_tile : '0;
        placed_so_far <= pend_valid ? pend_cnt : '0;
      end
    end
  end

  always_comb begin
    pool_we    = 1'b0;
    pool_waddr = rmd[POOL_ADDR_W-1:0];
    pool_wdata = tile_q;
    if (cmd.append) begin
      pool_we    = 1'b1;
      pool_waddr = pool_count[POOL_ADDR_W-1:0];
    end else if (cmd.rep_wr) begin
      pool_we    = 1'b1;
    end else if (cmd.swap_wr) begin
      pool_we    = 1'b1;
      pool_wdata = pool_rdata;
    end
  end

  assign pool_raddr = cmd.rd_last ? POOL_ADDR_W'(rem - 1'b1) : rmd[POOL_ADDR_W-1:0];

  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = t[MAP_ADDR_W-1:0];
    occ_wdata = 1'b1;
    if (cmd.clr_step) begin
      occ_we    = 1'b1;
      occ_waddr = clr_addr;
      occ_wdata = 1'b0;
    end else if (cmd.mark_wr) begin
      occ_we    = 1'b1;
      occ_waddr = tile_q[MAP_ADDR_W-1:0];
    end else if (cmd.place) begin
      occ_we    = 1'b1;
    end
  end

  rsrd_ram #(.WIDTH(TILE_W), .DEPTH(POOL_DEPTH)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  rsrd_ram #(.WIDTH(1), .DEPTH(MAP_TILES)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (t[MAP_ADDR_W-1:0]),
    .rdata (occ_rdata)
  );

  always_comb begin
    sts.kind        = kind_q;
    sts.clr_last    = (clr_addr == CLR_END);
    sts.below_cap   = (CAP_W'(pool_count) < cap_now);
    sts.div_busy    = div_run;
    sts.j_lt_cap    = ({1'b0, rmd} < 16'(cap_now));
    sts.want_zero   = (want_q == '0);
    sts.rem_zero    = (rem == '0);
    sts.placed_full = (placed >= want_q);
    // a tile at or beyond the map size would count as occupied; with 16-bit tiles none is
    sts.occ_busy    = occ_rdata || (32'(t) >= 32'(MAP_TILES));
  end

endmodule

// File: rtl/rsrd_ctrl.sv
// Controller state machine of the reservoir sampler.
module rsrd_ctrl
  import rsrd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_OFF_DIVS,
    ST_OFF_DIVW,
    ST_OFF_WR,
    ST_DRW_CHK,
    ST_DRW_DIVS,
    ST_DRW_DIVW,
    ST_DRW_RDP,
    ST_DRW_RDL,
    ST_DRW_SWP,
    ST_DRW_OCC,
    ST_DRW_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.kind)
          KIND_OFFER: begin
            cmd.seen_inc = 1'b1;
            if (sts.below_cap) begin
              cmd.append = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cmd.rng_step = 1'b1;
              state_next   = ST_OFF_DIVS;
            end
          end
          KIND_DRAW: begin
            cmd.draw_init = 1'b1;
            state_next    = ST_DRW_CHK;
          end
          KIND_MARK: begin
            cmd.mark_wr = 1'b1;
            state_next  = ST_IDLE;
          end
          KIND_RESTART: begin
            cmd.restart = 1'b1;
            state_next  = ST_IDLE;
          end
        endcase
      end
      ST_OFF_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_OFF_DIVW;
      end
      ST_OFF_DIVW: begin
        if (!sts.div_busy) begin
          state_next = ST_OFF_WR;
        end
      end
      ST_OFF_WR: begin
        cmd.rep_wr = sts.j_lt_cap;
        state_next = ST_IDLE;
      end
      ST_DRW_CHK: begin
        if (sts.want_zero || sts.rem_zero || sts.placed_full) begin
          state_next = ST_DRW_FIN;
        end else begin
          cmd.rng_step = 1'b1;
          state_next   = ST_DRW_DIVS;
        end
      end
      ST_DRW_DIVS: begin
        cmd.div_start = 1'b1;
        cmd.div_draw  = 1'b1;
        state_next    = ST_DRW_DIVW;
      end
      ST_DRW_DIVW: begin
        if (!sts.div_busy) begin
          state_next = ST_DRW_RDP;
        end
      end
      ST_DRW_RDP: begin
        state_next = ST_DRW_RDL;
      end
      ST_DRW_RDL: begin
        cmd.latch_t = 1'b1;
        cmd.rd_last = 1'b1;
        state_next  = ST_DRW_SWP;
      end
      ST_DRW_SWP: begin
        cmd.swap_wr = 1'b1;
        state_next  = ST_DRW_OCC;
      end
      ST_DRW_OCC: begin
        cmd.place  = !sts.occ_busy;
        state_next = ST_DRW_CHK;
      end
      ST_DRW_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: verif/tb_reservoir_sampler_random_draw_top.sv
// Testbench for the reservoir sampler: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module tb_reservoir_sampler_random_draw_top;
  import rsrd_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic              valid;
    logic [WANT_W-1:0] so_far;
    logic              fin;
  } placement_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        kind = '0;
  logic [TILE_W-1:0] tile_index = '0;
  logic [WANT_W-1:0] want = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = 1'b0;
  logic [31:0]       cfg_data = '0;
  logic              strobe;
  logic [TILE_W-1:0] placed_tile;
  logic              placed_valid;
  logic [WANT_W-1:0] placed_so_far;
  logic              last;

  reservoir_sampler_random_draw_top dut (.*);

  // Predictor state: the reservoir, the generator and the occupancy map
  logic [8:0]        cap_reg;
  logic [31:0]       seed_reg;
  logic [31:0]       lcg;
  logic [TILE_W-1:0] pool [POOL_DEPTH];
  int unsigned       pool_cnt;
  logic [31:0]       seen;
  bit                occupied [MAP_TILES];

  placement_t placements_due[$];
  int  fail_count = 0;
  int  burst_left;
  longint cycle_cnt = 0;

  initial forever #CLK_HALF clk = ~clk;

  // Watchdog: allow for the map clearing pass and the slowest draws
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [14:0] next_rand();
    lcg = lcg * LCG_MUL + LCG_INC;
    return lcg[30:16];
  endfunction

  // Work out what one accepted item does to the state and which placements it gives
  function automatic void predict_item(kind_t k, logic [TILE_W-1:0] t, logic [WANT_W-1:0] w);
    int unsigned cap_eff, rem, placed, wanted, pick;
    logic [31:0] j;
    logic [TILE_W-1:0] got;
    placement_t p;
    cap_eff = (cap_reg > POOL_DEPTH) ? POOL_DEPTH : cap_reg;
    case (k)
      KIND_OFFER: begin
        if (seen != 32'hFFFF_FFFF) seen = seen + 1;
        if (pool_cnt < cap_eff) begin
          pool[pool_cnt] = t;
          pool_cnt++;
        end else begin
          j = {17'd0, next_rand()} % seen;
          if (j < cap_eff) pool[j] = t;
        end
      end
      KIND_MARK: occupied[t] = 1'b1;
      KIND_RESTART: begin
        pool_cnt = 0;
        seen = '0;
        lcg = (seed_reg == 0) ? 32'd1 : seed_reg;
      end
      default: begin
        wanted = (w > MAX_WANT) ? MAX_WANT : w;
        placed = 0;
        rem = pool_cnt;
        if (wanted != 0) begin
          while (rem > 0 && placed < wanted) begin
            pick = next_rand() % rem;
            got = pool[pick];
            pool[pick] = pool[rem - 1];
            rem--;
            if (occupied[got]) continue;
            occupied[got] = 1'b1;
            placed++;
            p.tile = got; p.valid = 1'b1; p.so_far = WANT_W'(placed); p.fin = 1'b0;
            placements_due.push_back(p);
          end
          pool_cnt = rem;
        end
        if (placed == 0) begin
          p = '0;
          p.fin = 1'b1;
          placements_due.push_back(p);
        end else begin
          p = placements_due.pop_back();
          p.fin = 1'b1;
          placements_due.push_back(p);
        end
      end
    endcase
  endfunction

  // Compare every strobed result with the oldest placement still due
  always @(posedge clk) begin
    placement_t exp_p;
    if (!rst && strobe) begin
      if (placements_due.size() == 0) begin
        $error("unexpected result: tile %0d valid %0d", placed_tile, placed_valid);
        fail_count++;
      end else begin
        exp_p = placements_due.pop_front();
        if (placed_tile !== exp_p.tile) begin
          $error("placed_tile expected %0d actual %0d", exp_p.tile, placed_tile);
          fail_count++;
        end
        if (placed_valid !== exp_p.valid) begin
          $error("placed_valid expected %0d actual %0d", exp_p.valid, placed_valid);
          fail_count++;
        end
        if (placed_so_far !== exp_p.so_far) begin
          $error("placed_so_far expected %0d actual %0d", exp_p.so_far, placed_so_far);
          fail_count++;
        end
        if (last !== exp_p.fin) begin
          $error("last expected %0d actual %0d", exp_p.fin, last);
          fail_count++;
        end
      end
    end
  end

  // Send one item; start is left high within a burst so the next transaction can follow back to back
  task automatic send_item(kind_t k, logic [TILE_W-1:0] t, logic [WANT_W-1:0] w);
    start      <= 1'b1;
    kind       <= k;
    tile_index <= t;
    want       <= w;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_item(k, t, w);
    // Burst pacing: drop start for a random gap once the burst runs out
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 12);
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Hold off until every due placement has arrived and the block has gone idle
  task automatic drain();
    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (placements_due.size() == 0 && !busy) break;
    end
    repeat (SETTLE) @(posedge clk);
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_CAPACITY) cap_reg = val[8:0];
    else seed_reg = val;
    @(posedge clk);
  endtask

  function automatic logic [TILE_W-1:0] pick_tile();
    // Half from a narrow range so marks and repeats collide with pool entries
    return ($urandom_range(0, 1) == 0) ? TILE_W'($urandom_range(0, 63)) : TILE_W'($urandom);
  endfunction

  task automatic test_edges();
    send_item(KIND_DRAW, 16'hFFFF, 7'd5);          // empty pool: empty transaction
    send_item(KIND_OFFER, 16'h0000, 7'h7F);
    send_item(KIND_OFFER, 16'hFFFF, 7'd0);
    send_item(KIND_OFFER, 16'h1234, 7'd0);
    send_item(KIND_OFFER, 16'h00AA, 7'd0);
    send_item(KIND_DRAW, 16'h0000, 7'd0);          // want zero leaves the pool alone
    send_item(KIND_MARK, 16'h1234, 7'd0);          // occupied entry is dropped when a draw picks it
    send_item(KIND_MARK, 16'hFFFF, 7'h7F);
    send_item(KIND_DRAW, 16'h0000, 7'd2);
    send_item(KIND_DRAW, 16'hAAAA, 7'h7F);         // want saturates
    send_item(KIND_DRAW, 16'h5555, 7'd64);
    send_item(KIND_OFFER, 16'h00AA, 7'd0);         // already placed, so occupied
    send_item(KIND_DRAW, 16'h0000, 7'd1);
    drain();
  endtask

  task automatic test_capacity_edges();
    int unsigned caps [4] = '{0, 1, 256, 511};
    foreach (caps[c]) begin
      write_reg(CFG_CAPACITY, caps[c]);
      write_reg(CFG_SEED, (c % 2) ? 32'hFFFF_FFFF : 32'd0);
      send_item(KIND_RESTART, pick_tile(), 7'd0);
      repeat (6) send_item(KIND_OFFER, pick_tile(), 7'd0);
      send_item(KIND_DRAW, 16'd0, 7'd3);
      drain();
    end
    // Lower capacity below the count: the existing entries stay
    write_reg(CFG_CAPACITY, 32'd8);
    send_item(KIND_RESTART, 16'd0, 7'd0);
    repeat (8) send_item(KIND_OFFER, pick_tile(), 7'd0);
    drain();
    write_reg(CFG_CAPACITY, 32'd2);
    repeat (4) send_item(KIND_OFFER, pick_tile(), 7'd0);
    send_item(KIND_DRAW, 16'd0, 7'd64);
    drain();
  endtask

  task automatic test_random();
    int unsigned sent, n, r;
    logic [31:0] cap_val;
    sent = 0;
    while (sent < 340) begin
      r = $urandom_range(0, 9);
      cap_val = (r == 0) ? 32'd256 : (r == 1) ? $urandom_range(257, 511) :
                (r == 2) ? 32'd0 : $urandom_range(1, 32);
      write_reg(CFG_CAPACITY, cap_val | ($urandom & 32'hFFFF_FE00));
      write_reg(CFG_SEED, $urandom);
      send_item(KIND_RESTART, pick_tile(), WANT_W'($urandom));
      n = $urandom_range(20, 60);
      repeat (n) begin
        r = $urandom_range(0, 19);
        if (r < 10)
          send_item(KIND_OFFER, pick_tile(), WANT_W'($urandom));
        else if (r < 15)
          send_item(KIND_DRAW, TILE_W'($urandom), ($urandom_range(0, 4) == 0) ?
                    WANT_W'($urandom) : WANT_W'($urandom_range(0, 8)));
        else if (r < 19)
          send_item(KIND_MARK, pick_tile(), WANT_W'($urandom));
        else
          send_item(KIND_RESTART, pick_tile(), WANT_W'($urandom));
      end
      sent += n + 1;
      drain();
    end
  endtask

  initial begin
    burst_left = 0;
    cap_reg    = 9'd64;
    seed_reg   = 32'd1;
    lcg        = 32'd1;
    pool_cnt   = 0;
    seen       = '0;
    foreach (pool[i]) pool[i] = '0;
    foreach (occupied[i]) occupied[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edges();
    test_capacity_edges();
    test_random();

    if (fail_count == 0 && placements_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/rsrd_pkg.sv
rtl/rsrd_ram.sv
rtl/rsrd_datapath.sv
rtl/rsrd_ctrl.sv
rtl/reservoir_sampler_random_draw_top.sv
verif/tb_reservoir_sampler_random_draw_top.sv
